// ===== hdl/fbd_pkg.sv =====
package fbd_pkg;

   localparam int PCLK_W      = 27;
   localparam int BAUD_W      = 22;
   localparam int DL_W        = 16;
   localparam int NIB_W       = 4;
   localparam int BASE_ENTRIES = 72;
   localparam int TABLE_ENTRIES_DEF = 72;
   localparam int PCLK_RESET  = 100000000;

   // dividend width: pclk*65536 needs 43 bits, pclk*1000 needs 37
   localparam int DIV_W       = 43;
   localparam int QUO_W       = 43;

   localparam logic [10:0] SEED_START   = 11'd1500;
   localparam logic [10:0] SEED_LOW     = 11'd1100;
   localparam logic [10:0] SEED_RESTART = 11'd1501;
   localparam logic [10:0] SEED_HIGH    = 11'd1899;

   function automatic logic [10:0] base_milli(input logic [6:0] i);
      logic [10:0] t [0:BASE_ENTRIES-1];
      t = '{1000,1067,1071,1077,1083,1091,1100,1111,1125,1133,1143,1154,1167,1182,1200,1214,
            1222,1231,1250,1267,1273,1286,1300,1308,1333,1357,1364,1375,1385,1400,1417,1429,
            1444,1455,1462,1467,1500,1533,1538,1545,1556,1571,1583,1600,1615,1625,1636,1643,
            1667,1692,1700,1714,1727,1733,1750,1769,1778,1786,1800,1818,1833,1846,1857,1867,
            1875,1889,1900,1909,1917,1923,1929,1933};
      return (i < 7'(BASE_ENTRIES)) ? t[i] : 11'd0;
   endfunction

   function automatic logic [NIB_W-1:0] base_add(input logic [6:0] i);
      logic [3:0] t [0:BASE_ENTRIES-1];
      t = '{0,1,1,1,1,1,1,1,1,2,1,2,1,2,1,3,2,3,1,4,3,2,3,4,1,5,4,3,5,2,5,3,4,5,6,7,1,8,7,6,
            5,4,7,3,8,5,7,9,2,9,7,5,8,11,3,10,7,11,4,9,5,11,6,13,7,8,9,10,11,12,13,14};
      return (i < 7'(BASE_ENTRIES)) ? t[i] : 4'd0;
   endfunction

   function automatic logic [NIB_W-1:0] base_mul(input logic [6:0] i);
      logic [3:0] t [0:BASE_ENTRIES-1];
      t = '{1,15,14,13,12,11,10,9,8,15,7,13,6,11,5,14,9,13,4,15,11,7,10,13,3,14,11,8,13,5,
            12,7,9,11,13,15,2,15,13,11,9,7,12,5,13,8,11,14,3,13,10,7,11,15,4,13,9,14,5,11,6,
            13,7,15,8,9,10,11,12,13,14,15};
      return (i < 7'(BASE_ENTRIES)) ? t[i] : 4'd1;
   endfunction

   typedef logic [BASE_ENTRIES-1:0][16:0] ratio_tbl_type;

   // ratios in 1.16, rounded to nearest, built at elaboration
   function automatic ratio_tbl_type build_ratios();
      ratio_tbl_type r;
      logic [27:0]   p;
      for (int k = 0; k < BASE_ENTRIES; k++) begin
         p = 28'(base_milli(7'(k))) * 28'd65536 + 28'd500;
         r[k] = 17'(p / 28'd1000);
      end
      return r;
   endfunction

   localparam ratio_tbl_type RATIO_TBL = build_ratios();

   function automatic logic [16:0] base_ratio(input logic [6:0] i);
      return (i < 7'(BASE_ENTRIES)) ? RATIO_TBL[i] : 17'd0;
   endfunction

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [QUO_W-1:0] quo;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

// ===== hdl/fractional_baud_divider_search_unit.sv =====
// Fractional baud divider search.
// Channels: req_ (tdata = baud_rate[21:0], zero-filled to 24 bits) and rsp_
// (tdata = divisor[15:0], div_add[19:16], mul_val[23:20], status[24], to 32 bits).
// csr_wr_en/csr_wr_data write pclk_hz; write only while idle.
// One request at a time: req_tready is high only when idle and no result waits.
// Each quotient comes from one shared restoring divider. Exact-fit check:
// 1 division. Each seed trial: 1 division, plus 1 more for the ratio of the
// fitting seed. Up to 800 seed trials; a zero baud rate skips the divider.
// The table scan then steps through the entries in order, up to the smaller of
// TABLE_ENTRIES and BASE_ENTRIES. Constants 16, 10, 11, 19 are applied by
// shift-and-add, 1000 by shift-and-subtract.
// Reset: pclk_hz returns to 100 MHz, the sequencer idles, no result is held.
// A stalled receiver keeps the result in the output register; no new transfer
// is taken until it leaves. Status 1 reports zero baud, a zero or oversize
// divisor, no fitting seed, or a table scan without a rise in distance.
module fractional_baud_divider_search_unit
   import fbd_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // baud_rate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // divisor, div_add, mul_val, status
   input  logic        csr_wr_en,
   input  logic [26:0] csr_wr_data  // pclk_hz
);

   localparam int SCAN_N = (TABLE_ENTRIES < BASE_ENTRIES) ? TABLE_ENTRIES : BASE_ENTRIES;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EXACT = 9'b000000010,
      ST_WEX   = 9'b000000100,
      ST_SEED  = 9'b000001000,
      ST_WQ    = 9'b000010000,
      ST_CHK   = 9'b000100000,
      ST_WFR   = 9'b001000000,
      ST_SCAN  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [PCLK_W-1:0] pclk_ff;
   logic [BAUD_W+3:0] b16_ff, b16_in;
   logic [10:0]      seed_ff, seed_in;
   logic             up_ff, up_in;
   logic [QUO_W-1:0] dl_ff, dl_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [QUO_W-1:0] fr_ff, fr_in;
   logic [6:0]       idx_ff, idx_in;
   logic [QUO_W-1:0] last_ff, last_in;
   logic [DL_W-1:0]  o_div_ff, o_div_in;
   logic [NIB_W-1:0] o_add_ff, o_add_in, o_mul_ff, o_mul_in;
   logic             o_st_ff, o_st_in;
   logic             vld_ff, vld_in;
   div_req_type      dreq;
   div_rsp_type      drsp;
   logic [QUO_W-1:0] diffv, ratio_w;
   logic [DIV_W+4:0] p10, d11, d19;

   fbd_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign req_tready = (state_ff == ST_IDLE) && !vld_ff;
   assign ratio_w    = QUO_W'(base_ratio(idx_ff));
   assign diffv      = (fr_ff > ratio_w) ? fr_ff - ratio_w : ratio_w - fr_ff;
   // ratio compare against 1.1 and 1.9 via shift-and-add
   assign p10 = (48'(pclk_ff) << 3) + (48'(pclk_ff) << 1);
   assign d11 = (48'(d_ff) << 3) + (48'(d_ff) << 1) + 48'(d_ff);
   assign d19 = (48'(d_ff) << 4) + (48'(d_ff) << 1) + 48'(d_ff);

   always_comb begin
      state_in = state_ff;
      b16_in = b16_ff; seed_in = seed_ff; up_in = up_ff;
      dl_in = dl_ff; d_in = d_ff; fr_in = fr_ff; idx_in = idx_ff; last_in = last_ff;
      o_div_in = o_div_ff; o_add_in = o_add_ff; o_mul_in = o_mul_ff; o_st_in = o_st_ff;
      vld_in = vld_ff;
      dreq = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               b16_in = {req_tdata[BAUD_W-1:0], 4'b0};
               o_div_in = '0; o_add_in = '0; o_mul_in = 4'd1; o_st_in = 1'b1;
               if (req_tdata[BAUD_W-1:0] == '0) state_in = ST_OUT;
               else state_in = ST_EXACT;
            end
         end
         ST_EXACT: begin
            dreq.start = 1'b1;
            dreq.num = DIV_W'(pclk_ff);
            dreq.den = DIV_W'(b16_ff);
            state_in = ST_WEX;
         end
         ST_WEX: begin
            if (drsp.done) begin
               if (drsp.rem == '0) begin
                  dl_in = drsp.quo;
                  if (drsp.quo != '0 && drsp.quo <= QUO_W'(16'hFFFF)) begin
                     o_div_in = drsp.quo[DL_W-1:0]; o_st_in = 1'b0;
                  end
                  state_in = ST_OUT;
               end else begin
                  seed_in = SEED_START; up_in = 1'b0; state_in = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            // DL = pclk*1000 / (b16*seed); b16*DL is formed in ST_CHK
            dreq.start = 1'b1;
            dreq.num = (DIV_W'(pclk_ff) << 10) - (DIV_W'(pclk_ff) << 4)
                       - (DIV_W'(pclk_ff) << 3);
            dreq.den = DIV_W'(b16_ff) * DIV_W'(seed_ff);
            state_in = ST_WQ;
         end
         ST_WQ: begin
            if (drsp.done) begin
               dl_in = drsp.quo;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (d_ff == '0 && dl_ff != '0) begin
               d_in = DIV_W'(b16_ff) * DIV_W'(dl_ff[23:0]);
            end else if (dl_ff != '0 && p10 >= d11 && p10 < d19) begin
               dreq.start = 1'b1;
               dreq.num = DIV_W'(pclk_ff) << 16;
               dreq.den = d_ff;
               state_in = ST_WFR;
            end else begin
               d_in = '0;
               if (!up_ff) begin
                  if (seed_ff == SEED_LOW) begin
                     seed_in = SEED_RESTART; up_in = 1'b1; state_in = ST_SEED;
                  end else begin
                     seed_in = seed_ff - 11'd1; state_in = ST_SEED;
                  end
               end else if (seed_ff == SEED_HIGH) state_in = ST_OUT;
               else begin
                  seed_in = seed_ff + 11'd1; state_in = ST_SEED;
               end
            end
         end
         ST_WFR: begin
            if (drsp.done) begin
               fr_in = drsp.quo; idx_in = '0; d_in = '0; state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff != '0 && diffv > last_ff) begin
               if (dl_ff <= QUO_W'(16'hFFFF)) begin
                  o_div_in = dl_ff[DL_W-1:0];
                  o_add_in = base_add(idx_ff - 7'd1);
                  o_mul_in = base_mul(idx_ff - 7'd1);
                  o_st_in  = 1'b0;
               end
               state_in = ST_OUT;
            end else begin
               last_in = diffv;
               if (idx_ff == 7'(SCAN_N - 1)) state_in = ST_OUT;
               else idx_in = idx_ff + 7'd1;
            end
         end
         ST_OUT: begin
            vld_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         pclk_ff  <= PCLK_W'(PCLK_RESET);
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         d_ff     <= d_in;
         if (csr_wr_en) pclk_ff <= csr_wr_data;
      end
      b16_ff <= b16_in; seed_ff <= seed_in; up_ff <= up_in;
      dl_ff <= dl_in; fr_ff <= fr_in; idx_ff <= idx_in; last_ff <= last_in;
      o_div_ff <= o_div_in; o_add_ff <= o_add_in; o_mul_ff <= o_mul_in; o_st_ff <= o_st_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {7'b0, o_st_ff, o_mul_ff, o_add_ff, o_div_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_tready |=> vld_ff && $stable(rsp_tdata)) else $error("result dropped");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      vld_ff && o_st_ff |-> o_div_ff == '0 && o_mul_ff == 4'd1) else $error("bad failure result");

endmodule

// ===== hdl/fbd_divider.sv =====
module fbd_divider
   import fbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diffv;

   // restoring, one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diffv   = trial - {1'b0, den_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
         cnt_in  = 6'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diffv[DIV_W]) begin
            rem_in = diffv[DIV_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("busy at done");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 6'd0) else $error("counter left running");

endmodule

// ===== dv/tb_fractional_baud_divider_search_unit.sv =====
`timescale 1ns / 100ps

module tb_fractional_baud_divider_search_unit
   import fbd_pkg::*;
();

   localparam int MAX_BAUD  = 4194303;
   localparam int MAX_PCLK  = 120000000;
   localparam int N_RANDOM  = 100;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [DL_W-1:0]  divisor;
      logic [NIB_W-1:0] div_add;
      logic [NIB_W-1:0] mul_val;
      logic             status;
   } divider_setting_type;

   // one row of directed stimulus: either a clock setting or a baud rate
   typedef struct {
      bit                  is_clk;
      int unsigned         value;
      bit                  typed;
      divider_setting_type want;
   } stim_row_type;

   localparam divider_setting_type NO_FIT = '{divisor: 16'd0, div_add: 4'd0,
                                              mul_val: 4'd1, status: 1'b1};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // baud_rate[21:0], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // divisor[15:0], div_add[19:16], mul_val[23:20], status[24]
   logic        csr_wr_en;
   logic [26:0] csr_wr_data; // pclk_hz

   // fraction table: thousandths, add, multiply
   int unsigned frac_milli [72] = '{
      1000,1067,1071,1077,1083,1091,1100,1111,1125,1133,1143,1154,1167,1182,1200,1214,
      1222,1231,1250,1267,1273,1286,1300,1308,1333,1357,1364,1375,1385,1400,1417,1429,
      1444,1455,1462,1467,1500,1533,1538,1545,1556,1571,1583,1600,1615,1625,1636,1643,
      1667,1692,1700,1714,1727,1733,1750,1769,1778,1786,1800,1818,1833,1846,1857,1867,
      1875,1889,1900,1909,1917,1923,1929,1933};
   int unsigned frac_add [72] = '{
      0,1,1,1,1,1,1,1,1,2,1,2,1,2,1,3,2,3,1,4,3,2,3,4,1,5,4,3,5,2,5,3,4,5,6,7,1,8,7,6,
      5,4,7,3,8,5,7,9,2,9,7,5,8,11,3,10,7,11,4,9,5,11,6,13,7,8,9,10,11,12,13,14};
   int unsigned frac_mul [72] = '{
      1,15,14,13,12,11,10,9,8,15,7,13,6,11,5,14,9,13,4,15,11,7,10,13,3,14,11,8,13,5,
      12,7,9,11,13,15,2,15,13,11,9,7,12,5,13,8,11,14,3,13,10,7,11,15,4,13,9,14,5,11,6,
      13,7,15,8,9,10,11,12,13,14,15};

   divider_setting_type pending_settings [$];
   longint unsigned     model_pclk;
   int                  fail_count;
   int                  sent_count;
   int                  got_count;
   int                  fail_status_count;
   bit                  long_hold_req;

   fractional_baud_divider_search_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // seed trial: divisor for seed s, and whether pclk/(b16*DL) sits in [1.1, 1.9)
   function automatic bit seed_trial(longint unsigned pclk, longint unsigned b16,
                                     longint unsigned s, output longint unsigned dl,
                                     output longint unsigned fr);
      longint unsigned q;
      longint unsigned d;
      q  = pclk * 1000 / (b16 * s);
      dl = q;
      fr = 0;
      if (q == 0) return 1'b0;
      d = b16 * q;
      if (10 * pclk >= 11 * d && 10 * pclk < 19 * d) begin
         fr = (pclk << 16) / d;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic divider_setting_type search_divider(longint unsigned pclk,
                                                          longint unsigned baud);
      divider_setting_type res;
      longint unsigned     b16, dl, fr, r, diff, last;
      bit                  ok, found;
      int                  s, i;
      res = '{divisor: 16'd0, div_add: 4'd0, mul_val: 4'd1, status: 1'b0};
      ok = 1'b0;
      found = 1'b0;
      dl = 0;
      fr = 0;
      last = 0;
      if (baud == 0) return NO_FIT;
      b16 = 16 * baud;
      if (pclk % b16 == 0) begin
         dl = pclk / b16;
         ok = 1'b1;
      end else begin
         // downward sweep first, then the restart above the midpoint
         for (s = 1500; s >= 1100 && !found; s--)
            found = seed_trial(pclk, b16, s, dl, fr);
         for (s = 1501; s <= 1899 && !found; s++)
            found = seed_trial(pclk, b16, s, dl, fr);
         if (found) begin
            // nearest entry: stop at the first rise in distance
            for (i = 0; i < 72 && !ok; i++) begin
               r    = (frac_milli[i] * 65536 + 500) / 1000;
               diff = (fr > r) ? fr - r : r - fr;
               if (i > 0 && diff > last) begin
                  res.div_add = 4'(frac_add[i-1]);
                  res.mul_val = 4'(frac_mul[i-1]);
                  ok = 1'b1;
               end
               last = diff;
            end
         end
      end
      if (!ok || dl == 0 || dl > 65535) return NO_FIT;
      res.divisor = dl[15:0];
      return res;
   endfunction

   task automatic set_pclk(int unsigned value);
      // only while idle: drain, then let the sequencer settle
      while (pending_settings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[26:0];
      @(posedge clock);
      model_pclk = 64'(value[26:0]);
      csr_wr_en <= 1'b0;
   endtask

   // offer one baud rate, hold until the transfer, then maybe leave a gap
   task automatic send_baud(int unsigned baud, bit typed, divider_setting_type want);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, baud[21:0]};
      do @(posedge clock); while (!req_tready);
      pending_settings.push_back(typed ? want : search_divider(model_pclk, 64'(baud)));
      sent_count++;
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // pick a baud rate: mostly one that leaves room for a divisor, some anywhere
   function automatic int unsigned pick_baud(longint unsigned pclk);
      longint unsigned top;
      top = pclk / 32;
      if (top > MAX_BAUD) top = MAX_BAUD;
      if (top < 1 || $urandom_range(0, 19) == 0) return $urandom_range(0, MAX_BAUD);
      if ($urandom_range(0, 9) == 0) return $urandom_range(1, 64);
      return $urandom_range(1, 32'(top));
   endfunction

   // result side: random back-pressure, a few long stalls, one requested long hold
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if ($urandom_range(0, 49) == 0) begin
            stall = $urandom_range(20, 100);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
            @(posedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      divider_setting_type want;
      divider_setting_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{divisor: rsp_tdata[15:0], div_add: rsp_tdata[19:16],
                 mul_val: rsp_tdata[23:20], status: rsp_tdata[24]};
         got_count++;
         if (got.status) fail_status_count++;
         if (pending_settings.size() == 0) begin
            $error("unexpected result transfer: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_settings.pop_front();
            if (got.divisor !== want.divisor) begin
               $error("divisor: expected %0d actual %0d", want.divisor, got.divisor);
               fail_count++;
            end
            if (got.div_add !== want.div_add) begin
               $error("div_add: expected %0d actual %0d", want.div_add, got.div_add);
               fail_count++;
            end
            if (got.mul_val !== want.mul_val) begin
               $error("mul_val: expected %0d actual %0d", want.mul_val, got.mul_val);
               fail_count++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, got.status);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      stim_row_type        rows [$];
      divider_setting_type none;
      int                  phase, n;
      none = NO_FIT;

      // reset values plus the extremes of clock and baud
      rows.push_back('{0, 0,       1, NO_FIT});                       // zero baud
      rows.push_back('{0, 1,       1, NO_FIT});                       // exact fit, oversize
      rows.push_back('{0, 62500,   1, '{16'd100, 4'd0, 4'd1, 1'b0}}); // exact fit
      rows.push_back('{0, 115200,  0, none});
      rows.push_back('{0, 9600,    0, none});
      rows.push_back('{0, 4194303, 0, none});                         // seed fits at 1.49
      rows.push_back('{1, 0,       0, none});                         // zero clock
      rows.push_back('{0, 1,       1, NO_FIT});
      rows.push_back('{0, 4194303, 1, NO_FIT});
      rows.push_back('{1, 1,       0, none});
      rows.push_back('{0, 1,       1, NO_FIT});                       // no seed fits
      rows.push_back('{1, MAX_PCLK, 0, none});
      rows.push_back('{0, 1,       0, none});
      rows.push_back('{0, 7500000 / 16, 0, none});
      rows.push_back('{0, 57600,   0, none});
      rows.push_back('{0, 3000000, 0, none});
      rows.push_back('{1, 27'h7FF_FFFF, 0, none});                    // all clock bits set
      rows.push_back('{0, 1,       1, NO_FIT});                       // divisor oversize
      rows.push_back('{0, 2097152, 0, none});                         // ratio near 2, sweep
      rows.push_back('{0, 38400,   0, none});
      rows.push_back('{1, PCLK_RESET, 0, none});
      rows.push_back('{0, 19200,   0, none});

      fail_count = 0;
      sent_count = 0;
      got_count = 0;
      fail_status_count = 0;
      long_hold_req = 1'b0;
      model_pclk = 64'(PCLK_RESET);
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_clk) begin
            req_tvalid <= 1'b0;
            set_pclk(rows[i].value);
         end else
            send_baud(rows[i].value, rows[i].typed, rows[i].want);
      end

      // random phases, each under its own clock setting
      for (phase = 0; phase < 5; phase++) begin
         req_tvalid <= 1'b0;
         case (phase)
            0: set_pclk(MAX_PCLK);
            1: set_pclk($urandom_range(1000000, MAX_PCLK));
            2: set_pclk($urandom_range(0, 27'h7FF_FFFF));
            3: set_pclk($urandom_range(1, 4000000));
            default: set_pclk($urandom_range(1000000, MAX_PCLK));
         endcase
         // first phase: hold the result side off so the input stalls behind it
         if (phase == 0) long_hold_req = 1'b1;
         for (n = 0; n < N_RANDOM / 5; n++)
            send_baud(pick_baud(model_pclk), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_settings.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d baud requests, %0d results (%0d failure status)",
               sent_count, got_count, fail_status_count);
      $display("clock settings: reset, zero, one, maximum, all ones and random");
      if (fail_count == 0 && pending_settings.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/fbd_pkg.sv
hdl/fbd_divider.sv
hdl/fractional_baud_divider_search_unit.sv
dv/tb_fractional_baud_divider_search_unit.sv
